### design/kvp_pkg.sv
// shared types, constants and key name table for the key-value field line parser
`default_nettype none

package kvp_pkg;

    localparam int POS_W      = 13;
    localparam int NAME_COUNT = 13;
    localparam int NAME_MAXLEN = 9;

    localparam logic [POS_W-1:0] MAX_LINE_LEN = POS_W'(4096);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_KEY,
        PH_COLON,
        PH_VBLANK,
        PH_VALUE,
        PH_REJECT
    } phase_t;

    typedef enum logic [2:0] {
        KIND_UNKNOWN,
        KIND_DATE,
        KIND_PRIORITY,
        KIND_TAGS,
        KIND_TEXT
    } kind_t;

    typedef struct packed {
        phase_t                  phase;
        logic [POS_W-1:0]        position;
        logic [POS_W-1:0]        key_begin;
        logic [POS_W-1:0]        key_finish;
        logic [POS_W-1:0]        value_begin;
        logic [POS_W-1:0]        value_end;
        logic [NAME_COUNT-1:0]   cands;
        logic                    overflow;
    } kvp_state_t;

    localparam kvp_state_t STATE_RESET = '{
        phase:       PH_LEAD,
        position:    '0,
        key_begin:   '0,
        key_finish:  '0,
        value_begin: '0,
        value_end:   '0,
        cands:       '1,
        overflow:    1'b0
    };

    // names right-aligned: last character in the low byte
    localparam logic [8*NAME_MAXLEN-1:0] NAME_TEXT [NAME_COUNT] = '{
        72'("deadline"), 72'("due"), 72'("schedule"),
        72'("scheduled"), 72'("completed"), 72'("created"),
        72'("archived"),
        72'("prio"), 72'("priority"),
        72'("tags"),
        72'("owner"), 72'("assignee"), 72'("id")
    };

    localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
        4'd8, 4'd3, 4'd8, 4'd9, 4'd9, 4'd7, 4'd8,
        4'd4, 4'd8,
        4'd4,
        4'd5, 4'd8, 4'd2
    };

    localparam kind_t NAME_KIND [NAME_COUNT] = '{
        KIND_DATE, KIND_DATE, KIND_DATE, KIND_DATE, KIND_DATE, KIND_DATE, KIND_DATE,
        KIND_PRIORITY, KIND_PRIORITY,
        KIND_TAGS,
        KIND_TEXT, KIND_TEXT, KIND_TEXT
    };

    function automatic logic [NAME_COUNT-1:0] narrow_mask(
        input logic [NAME_COUNT-1:0] mask,
        input logic [POS_W-1:0]      offset,
        input logic [7:0]            c
    );
        logic [NAME_COUNT-1:0] m;
        logic [3:0]            idx;
        logic [7:0]            b;
        m = mask;
        for (int i = 0; i < NAME_COUNT; i++) begin
            b = '0;
            idx = 4'(NAME_LEN[i] - 4'd1 - offset[3:0]);
            if (offset < POS_W'(NAME_LEN[i])) begin
                b = NAME_TEXT[i][8*idx +: 8];
            end
            if (!((offset < POS_W'(NAME_LEN[i])) && (b == c))) begin
                m[i] = 1'b0;
            end
        end
        return m;
    endfunction

    function automatic kind_t find_kind(
        input logic [NAME_COUNT-1:0] mask,
        input logic [POS_W-1:0]      len
    );
        kind_t k;
        logic  found;
        k = KIND_UNKNOWN;
        found = 1'b0;
        for (int i = 0; i < NAME_COUNT; i++) begin
            if (!found && mask[i] && (len == POS_W'(NAME_LEN[i]))) begin
                k = NAME_KIND[i];
                found = 1'b1;
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

### design/kvp_char_step.sv
// per-character parse step: next phase, positions and name candidates
`default_nettype none

module kvp_char_step
    import kvp_pkg::*;
(
    input  wire kvp_state_t  cur,
    input  wire logic [7:0]  char_code,
    input  wire logic        has_char,
    output kvp_state_t       nxt
);

    logic [POS_W-1:0] p;
    logic [POS_W-1:0] nx;
    logic             is_letter;
    logic             is_key_char;
    logic             is_sp_tab;
    logic             is_trim;

    always_comb begin
        is_letter   = char_code inside {[8'h41:8'h5A], [8'h61:8'h7A]};
        is_key_char = is_letter || (char_code inside {[8'h30:8'h39], CH_UNDER, CH_DASH});
        is_sp_tab   = char_code inside {CH_SPACE, CH_TAB};
        is_trim     = char_code inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    end

    always_comb begin
        nxt = cur;
        p   = cur.position;
        nx  = (p < MAX_LINE_LEN) ? p + POS_W'(1) : MAX_LINE_LEN;
        if (has_char) begin
            if (p >= MAX_LINE_LEN) begin
                nxt.overflow = 1'b1;
            end
            nxt.position = nx;
            case (cur.phase)
                PH_LEAD: begin
                    if (!is_sp_tab) begin
                        if (is_letter) begin
                            nxt.key_begin = p;
                            nxt.phase     = PH_KEY;
                            nxt.cands     = narrow_mask(cur.cands, '0, char_code);
                        end else begin
                            nxt.phase = PH_REJECT;
                        end
                    end
                end
                PH_KEY: begin
                    if (is_key_char) begin
                        nxt.cands = narrow_mask(cur.cands, p - cur.key_begin, char_code);
                    end else if (char_code == CH_COLON) begin
                        nxt.key_finish = p;
                        nxt.phase      = PH_COLON;
                    end else begin
                        nxt.phase = PH_REJECT;
                    end
                end
                PH_COLON: begin
                    if (char_code == CH_COLON) begin
                        nxt.value_begin = nx;
                        nxt.value_end   = nx;
                        nxt.phase       = PH_VBLANK;
                    end else begin
                        nxt.phase = PH_REJECT;
                    end
                end
                PH_VBLANK: begin
                    if (is_sp_tab) begin
                        nxt.value_begin = nx;
                        nxt.value_end   = nx;
                    end else begin
                        nxt.value_begin = p;
                        nxt.value_end   = is_trim ? p : nx;
                        nxt.phase       = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (!is_trim) begin
                        nxt.value_end = nx;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### design/key_value_field_line_parser.sv
// top level: stream wrapper, parse state and result register of the field line parser
//
// The input stream carries one byte of a text line per word: tdata holds the byte,
// tuser says whether the byte is present, tlast marks the last word of the line.
// A word with tuser low and tlast high ends the line without a byte.
// For every line one result word leaves on the output stream, with the key and
// value positions in tdata and the valid flag, key kind and length overflow in tuser.
// Positions count from zero and saturate at 4096.
// Throughput is one word per cycle while no line end waits on a held result; the
// state update between the input register and the parse state register is combinational.
// The accepted last word of a line passes through the input register, and its result
// is registered in the result register that drives m_axis_tvalid.
// While a result waits on m_axis_tready, words that are not the end of a line
// still flow in; a following line end holds in the input register until the
// result register frees.
// After reset both registers are empty and the parser waits for the start of a line.

`default_nettype none

module key_value_field_line_parser
    import kvp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // char_code
    input  wire logic [0:0]  s_axis_tuser,   // has_char
    input  wire logic        s_axis_tlast,   // is_last

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // key_start, key_end, value_start, value_end, pad
    output logic [4:0]       m_axis_tuser    // is_field, field_kind, too_long
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_char_reg;
    logic        in_has_reg;
    logic        in_last_reg;

    kvp_state_t  state_reg;
    kvp_state_t  state_next;
    kvp_state_t  step_state;

    logic        m_valid_reg;
    logic        m_valid_next;
    logic [55:0] m_tdata_reg;
    logic [4:0]  m_tuser_reg;

    logic        s_accept;
    logic        advance;
    logic        line_done;
    logic        is_field;
    kind_t       kind;
    logic [55:0] res_tdata;
    logic [4:0]  res_tuser;

    assign advance       = in_valid_reg && (!in_last_reg || !m_valid_reg || m_axis_tready);
    assign line_done     = advance && in_last_reg;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    kvp_char_step u_step (
        .cur       (state_reg),
        .char_code (in_char_reg),
        .has_char  (in_has_reg),
        .nxt       (step_state)
    );

    always_comb begin
        is_field = (step_state.phase == PH_VBLANK) || (step_state.phase == PH_VALUE);
        kind = KIND_UNKNOWN;
        if (is_field && !step_state.overflow) begin
            kind = find_kind(step_state.cands, step_state.key_finish - step_state.key_begin);
        end
        res_tdata = '0;
        if (is_field) begin
            res_tdata = {4'b0000, step_state.value_end, step_state.value_begin,
                         step_state.key_finish, step_state.key_begin};
        end
        res_tuser = {step_state.overflow, kind, is_field};
    end

    always_comb begin
        state_next = state_reg;
        if (advance) begin
            state_next = in_last_reg ? STATE_RESET : step_state;
        end
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (line_done) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= STATE_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_char_reg <= s_axis_tdata;
            in_has_reg  <= s_axis_tuser[0];
            in_last_reg <= s_axis_tlast;
        end
        if (line_done) begin
            m_tdata_reg <= res_tdata;
            m_tuser_reg <= res_tuser;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // a rejected line carries no positions and no kind
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == '0) && (m_axis_tuser[3:1] == 3'd0))
        else $error("non-field result carries positions or kind");

    // an overflowed line never reports a known kind
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[4] |-> (m_axis_tuser[3:1] == 3'd0))
        else $error("overflowed line reports a key kind");

    // positions are ordered within a field
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[12:0] <= m_axis_tdata[25:13]) &&
            (m_axis_tdata[38:26] <= m_axis_tdata[51:39]))
        else $error("field positions out of order");

    // the parse state starts over after each line end
    assert property (@(posedge aclk) disable iff (!aresetn)
        line_done |=> (state_reg.phase == PH_LEAD) && (state_reg.position == '0))
        else $error("parse state not cleared after line end");

    // position never passes the line length bound
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.position <= MAX_LINE_LEN)
        else $error("position beyond line length bound");
`endif

endmodule

`default_nettype wire
